/* rtl/hbst_pkg.sv */
// Shared types, register codes and the half-sine table for the H-bridge driver.
// No dependencies; used by hbst_gen and hbridge_sine_trapezoid_driver.
`timescale 1ns / 1ps

package hbst_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINE_MODE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINE_STEP  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NULL       = 3'd4;

   localparam logic        RST_SINE_MODE  = 1'b1;
   localparam logic [15:0] RST_SINE_STEP  = 16'd510;
   localparam logic [7:0]  RST_DEAD_TICKS = 8'd24;
   localparam logic [15:0] RST_PULSE      = 16'd56000;
   localparam logic [15:0] RST_NULL       = 16'd24000;

   localparam int POS_BITS   = 6;
   localparam int STORED_LEN = 39;

   localparam logic [7:0] HALF_SINE [STORED_LEN] = '{
      8'd0,   8'd21,  8'd41,  8'd61,  8'd81,  8'd100, 8'd119, 8'd136,
      8'd153, 8'd169, 8'd184, 8'd198, 8'd210, 8'd221, 8'd230, 8'd238,
      8'd245, 8'd250, 8'd253, 8'd255, 8'd253, 8'd250, 8'd245, 8'd238,
      8'd230, 8'd221, 8'd210, 8'd198, 8'd184, 8'd169, 8'd153, 8'd136,
      8'd119, 8'd100, 8'd81,  8'd61,  8'd41,  8'd21,  8'd0
   };

   typedef struct packed {
      logic        sine_mode;
      logic [15:0] sine_step_ticks;
      logic [7:0]  dead_ticks;
      logic [15:0] pulse_ticks;
      logic [15:0] null_ticks;
   } cfg_type;

   typedef struct packed {
      logic b2_low;
      logic b1_low;
      logic b2_high;
      logic b1_high;
   } gate_type;

   // Positions past the stored table read as zero.
   function automatic logic [7:0] sine_value(input logic [POS_BITS-1:0] idx);
      logic [7:0] v;
      v = 8'd0;
      if (idx < POS_BITS'(STORED_LEN)) begin
         v = HALF_SINE[idx];
      end
      return v;
   endfunction

endpackage

/* rtl/hbst_gen.sv */
// Sine-table and trapezoid gate generators of the H-bridge driver.
// Depends on hbst_pkg for the configuration and gate types and the sine table.
`timescale 1ns / 1ps

module hbst_gen #(
   parameter int TABLE_LEN  = 39,
   parameter int DUTY_BITS  = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hbst_pkg::cfg_type      cfg,
   input  logic                   restart,
   input  logic                   tick,
   output hbst_pkg::gate_type     gates_next,
   output logic [DUTY_BITS-1:0]   duty1_next,
   output logic [DUTY_BITS-1:0]   duty2_next
);
   import hbst_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [2:0] {
      T_NULL_DEAD_A, T_NULL_A, T_POS_DEAD, T_POS,
      T_NULL_DEAD_B, T_NULL_B, T_NEG_DEAD, T_NEG
   } trap_step_type;

   logic [POS_BITS-1:0]   pos_ff, pos_in, pos_inc;
   logic                  half_pos_ff, half_pos_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in, tick_inc;
   trap_step_type         step_ff, step_in;
   gate_type              gates_ff, gates_in;
   logic [DUTY_BITS-1:0]  duty1_ff, duty1_in, duty2_ff, duty2_in;

   logic [15:0]           len, len_min;
   logic                  reached, wrap;
   logic [DUTY_BITS-1:0]  table_val;

   always_comb begin
      if (cfg.sine_mode) begin
         len = cfg.sine_step_ticks;
      end else if (!step_ff[0]) begin
         len = {8'd0, cfg.dead_ticks};
      end else if (step_ff == T_NULL_A || step_ff == T_NULL_B) begin
         len = cfg.null_ticks;
      end else begin
         len = cfg.pulse_ticks;
      end
      len_min  = (len == 16'd0) ? 16'd1 : len;
      tick_inc = tick_ff + COUNT_BITS'(1);
      reached  = CMP_W'(tick_inc) >= CMP_W'(len_min);
      pos_inc  = pos_ff + POS_BITS'(1);
      wrap     = {1'b0, pos_inc} >= (POS_BITS + 1)'(TABLE_LEN);
   end

   always_comb begin
      pos_in      = pos_ff;
      half_pos_in = half_pos_ff;
      step_in     = step_ff;
      gates_in    = gates_ff;
      duty1_in    = duty1_ff;
      duty2_in    = duty2_ff;
      tick_in     = reached ? '0 : tick_inc;
      table_val   = '0;
      if (reached) begin
         if (cfg.sine_mode) begin
            pos_in = wrap ? '0 : pos_inc;
            if (wrap) begin
               half_pos_in      = ~half_pos_ff;
               gates_in.b1_high = ~half_pos_ff;
               gates_in.b2_high = half_pos_ff;
            end
            table_val = DUTY_BITS'(sine_value(pos_in));
            duty1_in  = half_pos_in ? '0 : table_val;
            duty2_in  = half_pos_in ? table_val : '0;
         end else begin
            step_in = trap_step_type'(step_ff + 3'd1);
            case (step_ff)
               T_NULL_DEAD_A: gates_in.b2_low  = 1'b1;
               T_NULL_A:      gates_in.b1_low  = 1'b0;
               T_POS_DEAD:    gates_in.b1_high = 1'b1;
               T_POS:         gates_in.b1_high = 1'b0;
               T_NULL_DEAD_B: gates_in.b1_low  = 1'b1;
               T_NULL_B:      gates_in.b2_low  = 1'b0;
               T_NEG_DEAD:    gates_in.b2_high = 1'b1;
               default:       gates_in.b2_high = 1'b0;
            endcase
         end
      end
   end

   assign gates_next = gates_in;
   assign duty1_next = duty1_in;
   assign duty2_next = duty2_in;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pos_ff      <= '0;
         half_pos_ff <= 1'b1;
         tick_ff     <= '0;
         step_ff     <= T_NULL_DEAD_A;
         gates_ff    <= '0;
         duty1_ff    <= '0;
         duty2_ff    <= '0;
      end else if (tick) begin
         pos_ff      <= pos_in;
         half_pos_ff <= half_pos_in;
         tick_ff     <= tick_in;
         step_ff     <= step_in;
         gates_ff    <= gates_in;
         duty1_ff    <= duty1_in;
         duty2_ff    <= duty2_in;
      end
   end

endmodule

/* rtl/hbridge_sine_trapezoid_driver.sv */
// Top level of the H-bridge driver: stream channels, registers, fault guard.
// Depends on hbst_pkg and instantiates hbst_gen.
`timescale 1ns / 1ps

// Each transaction on the req_ channel is one time-base tick carrying the
// read-back levels of the four gate pins. For each one the block returns one
// transaction on the rsp_ channel with the gate levels and PWM duties that
// hold after that tick, or the fault flag with everything off.
// rsp_tvalid rises in the cycle after acceptance, and a new transaction
// is taken every cycle unless the receiver stalls: the generator update is
// a single combinational pass between the generator and output registers.
// When the receiver stalls, the result waits in the output register and
// req_tready drops until it is taken; nothing is lost or repeated.
// Registers are written through csr_wen, csr_index and csr_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
// Changing the mode restarts both generators with all gates off; a latched
// fault is kept. Synchronous reset loads the register defaults, restarts the
// generators, clears the fault latch and empties the output register.
module hbridge_sine_trapezoid_driver #(
   parameter int TABLE_LEN  = 39,
   parameter int DUTY_BITS  = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sense_b1_high, sense_b1_low, sense_b2_high, sense_b2_low
   input  logic [7:0]                               req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // b1_high_gate, b2_high_gate, b1_low_gate, b2_low_gate, b1_low_duty,
   // b2_low_duty, fault
   output logic [((2*DUTY_BITS+5+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                     csr_wen,
   input  logic [hbst_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [hbst_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import hbst_pkg::*;

   localparam int RSP_W     = ((2*DUTY_BITS+5+7)/8)*8;
   localparam int DUTY1_POS = 4;
   localparam int DUTY2_POS = 4 + DUTY_BITS;
   localparam int FAULT_POS = 4 + 2*DUTY_BITS;

   cfg_type              cfg_ff;
   logic                 fault_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic                 accept, sense_fault, fault_now, restart;
   gate_type             gates_next;
   logic [DUTY_BITS-1:0] duty1_next, duty2_next;

   assign req_tready  = !rsp_tvalid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign sense_fault = (req_tdata[0] && req_tdata[1]) || (req_tdata[2] && req_tdata[3]);
   assign fault_now   = fault_ff || sense_fault;
   assign restart     = csr_wen && csr_index == CSR_SINE_MODE
                        && csr_wdata[0] != cfg_ff.sine_mode;

   hbst_gen #(
      .TABLE_LEN  (TABLE_LEN),
      .DUTY_BITS  (DUTY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_gen (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .restart    (restart),
      .tick       (accept && !fault_now),
      .gates_next (gates_next),
      .duty1_next (duty1_next),
      .duty2_next (duty2_next)
   );

   always_comb begin
      rsp_tdata_in = '0;
      if (fault_now) begin
         rsp_tdata_in[FAULT_POS] = 1'b1;
      end else begin
         rsp_tdata_in[0] = gates_next.b1_high;
         rsp_tdata_in[1] = gates_next.b2_high;
         rsp_tdata_in[2] = !cfg_ff.sine_mode && gates_next.b1_low;
         rsp_tdata_in[3] = !cfg_ff.sine_mode && gates_next.b2_low;
         if (cfg_ff.sine_mode) begin
            rsp_tdata_in[DUTY1_POS +: DUTY_BITS] = duty1_next;
            rsp_tdata_in[DUTY2_POS +: DUTY_BITS] = duty2_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sine_mode       <= RST_SINE_MODE;
         cfg_ff.sine_step_ticks <= RST_SINE_STEP;
         cfg_ff.dead_ticks      <= RST_DEAD_TICKS;
         cfg_ff.pulse_ticks     <= RST_PULSE;
         cfg_ff.null_ticks      <= RST_NULL;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SINE_MODE:  cfg_ff.sine_mode       <= csr_wdata[0];
            CSR_SINE_STEP:  cfg_ff.sine_step_ticks <= csr_wdata;
            CSR_DEAD_TICKS: cfg_ff.dead_ticks      <= csr_wdata[7:0];
            CSR_PULSE:      cfg_ff.pulse_ticks     <= csr_wdata;
            CSR_NULL:       cfg_ff.null_ticks      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept && sense_fault) begin
            fault_ff <= 1'b1;
         end
         if (accept) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault latch cleared without reset");

   a_fault_all_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[FAULT_POS] |-> rsp_tdata[FAULT_POS-1:0] == '0)
      else $error("gate or duty active in a fault transaction");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while the output register is full");

   a_sine_low_off: assert property (@(posedge clock) disable iff (reset)
      accept && cfg_ff.sine_mode |=> !rsp_tdata[2] && !rsp_tdata[3])
      else $error("low-side gate driven in sine mode");

endmodule
